// ===== design/ampt_pkg.sv =====
`timescale 1ns / 1ps
package ampt_pkg;

	localparam int unsigned ID_W   = 6;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PRI_W  = 16;

	typedef enum logic [2:0] {
		REQ_ADD     = 3'd0,
		REQ_PROMOTE = 3'd1,
		REQ_GET_MAX = 3'd2,
		REQ_POP_MAX = 3'd3,
		REQ_IS_VAL  = 3'd4,
		REQ_GET     = 3'd5,
		REQ_RSVD6   = 3'd6,
		REQ_RSVD7   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [ID_W-1:0]   entry_id;
		logic [DATA_W-1:0] payload;
	} req_beat_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [DATA_W-1:0] result_payload;
		logic [PRI_W-1:0]  result_priority;
		logic              id_live;
		logic [1:0]        status;
	} rsp_beat_t;

	// best-so-far record passed along the cell chain
	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] payload;
		logic [PRI_W-1:0]  pri;
	} best_t;

	// request broadcast to all cells
	typedef struct packed {
		logic              add;
		logic              promote;
		logic              pop;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] payload;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage

// ===== design/ampt_cell.sv =====
`timescale 1ns / 1ps
module ampt_cell #(
	parameter logic [ampt_pkg::ID_W-1:0] CELL_ID = '0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ampt_pkg::cell_cmd_t cmd,
	input  ampt_pkg::best_t     best_in,
	output ampt_pkg::best_t     best_out,
	output logic                live,
	output logic [ampt_pkg::DATA_W-1:0] pay,
	output logic [ampt_pkg::PRI_W-1:0]  pri
);

	logic                        live_q;
	logic [ampt_pkg::DATA_W-1:0] pay_q;
	logic [ampt_pkg::PRI_W-1:0]  pri_q;
	logic                        hit;
	ampt_pkg::best_t             best_q;

	assign hit = (cmd.id == CELL_ID);

	// live mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (cmd.add && hit) begin
			live_q <= 1'b1;
		end else if (cmd.pop && hit) begin
			live_q <= 1'b0;
		end
	end

	// payload and priority store
	always_ff @(posedge clk) begin
		if (cmd.add && hit) begin
			pay_q <= cmd.payload;
			pri_q <= '0;
		end else if (cmd.promote && hit && live_q && (pri_q != '1)) begin
			pri_q <= pri_q + 1'b1;
		end
	end

	// max compare into the register handed to the next cell,
	// ties go to the higher id further down the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (live_q && (!best_in.found || pri_q >= best_in.pri)) begin
			best_q.found   <= 1'b1;
			best_q.id      <= CELL_ID;
			best_q.payload <= pay_q;
			best_q.pri     <= pri_q;
		end else begin
			best_q <= best_in;
		end
	end

	assign best_out = best_q;
	assign live     = live_q;
	assign pay      = pay_q;
	assign pri      = pri_q;

endmodule

// ===== design/addressable_max_priority_table.sv =====
`timescale 1ns / 1ps
// Addressable max-priority table over a chain of 64 cells, one per id. A request is
// taken when start is high and busy low; exactly one result appears on rsp with done
// high for one cycle, and the receiver cannot stall it. Get max and pop max keep busy
// high while the best entry ripples through the registered chain, then while cells
// are updated. Every other request keeps busy high for one cycle. done is high in the
// first cycle with busy low, and a new request can be taken at its end; a request
// is never taken while the previous one is still busy.
module addressable_max_priority_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ampt_pkg::req_beat_t req,
	output logic                busy,
	output logic                done,
	output ampt_pkg::rsp_beat_t rsp
);

	localparam int unsigned N   = 64;
	localparam int unsigned IDW = ampt_pkg::ID_W;
	localparam logic [IDW-1:0] SCAN_LAST = IDW'(N - 1);

	ampt_pkg::state_t    state_q;
	ampt_pkg::req_beat_t req_q;
	logic [ampt_pkg::ID_W:0] next_id_q;
	logic [IDW-1:0]      scan_cnt_q;
	ampt_pkg::cell_cmd_t cmd;
	ampt_pkg::best_t     chain [0:N];
	logic [N-1:0]        live_v;
	logic [ampt_pkg::DATA_W-1:0] pay_v [0:N-1];
	logic [ampt_pkg::PRI_W-1:0]  pri_v [0:N-1];
	ampt_pkg::rsp_beat_t rsp_d, rsp_q;
	logic                done_q;
	logic                sel_live;
	logic [ampt_pkg::PRI_W-1:0] sel_pri;

	assign chain[0] = '0;

	// cell chain
	for (genvar g = 0; g < N; g++) begin : g_cell
		ampt_cell #(.CELL_ID(IDW'(g))) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.best_in(chain[g]), .best_out(chain[g+1]),
			.live(live_v[g]), .pay(pay_v[g]), .pri(pri_v[g])
		);
	end

	assign sel_live = live_v[req_q.entry_id];
	assign sel_pri  = pri_v[req_q.entry_id];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ampt_pkg::S_IDLE;
			next_id_q  <= '0;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ampt_pkg::S_IDLE: begin
					if (start) begin
						scan_cnt_q <= '0;
						if (req.req_type inside {ampt_pkg::REQ_GET_MAX, ampt_pkg::REQ_POP_MAX})
							state_q <= ampt_pkg::S_SCAN;
						else
							state_q <= ampt_pkg::S_DONE;
					end
				end
				// wait until the chain end reflects the current table
				ampt_pkg::S_SCAN: begin
					if (scan_cnt_q == SCAN_LAST)
						state_q <= ampt_pkg::S_DONE;
					else
						scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				ampt_pkg::S_DONE: begin
					state_q <= ampt_pkg::S_IDLE;
					done_q  <= 1'b1;
					if (cmd.add) next_id_q <= next_id_q + 1'b1;
				end
				default: state_q <= ampt_pkg::S_IDLE;
			endcase
		end
	end

	// request latch and result register
	always_ff @(posedge clk) begin
		if (state_q == ampt_pkg::S_IDLE && start) req_q <= req;
		if (state_q == ampt_pkg::S_DONE) rsp_q <= rsp_d;
	end

	// result and cell update
	always_comb begin
		cmd = '0;
		cmd.id = req_q.entry_id;
		cmd.payload = req_q.payload;
		rsp_d = '0;
		if (state_q == ampt_pkg::S_DONE) begin
			case (req_q.req_type)
				ampt_pkg::REQ_ADD: begin
					if (next_id_q[ampt_pkg::ID_W]) begin
						rsp_d.status = ampt_pkg::ST_FULL;
					end else begin
						cmd.add = 1'b1;
						cmd.id  = next_id_q[ampt_pkg::ID_W-1:0];
						rsp_d.result_id      = next_id_q[ampt_pkg::ID_W-1:0];
						rsp_d.result_payload = req_q.payload;
						rsp_d.id_live        = 1'b1;
					end
				end
				ampt_pkg::REQ_PROMOTE: begin
					if (!sel_live) begin
						rsp_d.status = ampt_pkg::ST_BAD_ID;
					end else begin
						cmd.promote = 1'b1;
						rsp_d.result_id       = req_q.entry_id;
						rsp_d.result_payload  = pay_v[req_q.entry_id];
						rsp_d.result_priority = (sel_pri == '1) ? sel_pri : sel_pri + 1'b1;
						rsp_d.id_live         = 1'b1;
					end
				end
				ampt_pkg::REQ_GET_MAX, ampt_pkg::REQ_POP_MAX: begin
					if (!chain[N].found) begin
						rsp_d.status = ampt_pkg::ST_EMPTY;
					end else begin
						cmd.pop = (req_q.req_type == ampt_pkg::REQ_POP_MAX);
						cmd.id  = chain[N].id;
						rsp_d.result_id       = chain[N].id;
						rsp_d.result_payload  = chain[N].payload;
						rsp_d.result_priority = chain[N].pri;
						rsp_d.id_live         = 1'b1;
					end
				end
				ampt_pkg::REQ_IS_VAL: begin
					rsp_d.result_id = req_q.entry_id;
					if (sel_live) begin
						rsp_d.result_payload  = pay_v[req_q.entry_id];
						rsp_d.result_priority = sel_pri;
						rsp_d.id_live         = 1'b1;
					end
				end
				ampt_pkg::REQ_GET: begin
					if (!sel_live) begin
						rsp_d.status = ampt_pkg::ST_BAD_ID;
					end else begin
						rsp_d.result_id       = req_q.entry_id;
						rsp_d.result_payload  = pay_v[req_q.entry_id];
						rsp_d.result_priority = sel_pri;
						rsp_d.id_live         = 1'b1;
					end
				end
				default: rsp_d = '0;
			endcase
		end
	end

	assign busy = (state_q != ampt_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ampt_pkg::S_DONE)) else $error("done without finish");
	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= N) else $error("id counter overflow");
	a_one_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q != ampt_pkg::S_IDLE)) else $error("start lost");
`endif

endmodule

// ===== tb/ampt_checker.sv =====
`timescale 1ns / 1ps
module ampt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  ampt_pkg::req_beat_t req,
	input  logic                done,
	input  ampt_pkg::rsp_beat_t rsp,
	output int                  fail_count,
	output int                  pending
);

	logic [ampt_pkg::DATA_W-1:0] pay_mem [64];
	logic [ampt_pkg::PRI_W-1:0]  pri_mem [64];
	logic                        alive [64];
	int unsigned                 next_id;
	ampt_pkg::rsp_beat_t         want_mem [4];
	logic [1:0]                  wr_ptr;
	logic [1:0]                  rd_ptr;
	int                          fill;
	int                          mismatches;

	assign fail_count = mismatches;
	assign pending = fill;

	function automatic bit entry_live(logic [ampt_pkg::ID_W-1:0] id);
		return (id < next_id) && alive[id];
	endfunction

	function automatic ampt_pkg::rsp_beat_t show_entry(logic [ampt_pkg::ID_W-1:0] id);
		ampt_pkg::rsp_beat_t r;
		r.result_id = id;
		r.result_payload = pay_mem[id];
		r.result_priority = pri_mem[id];
		r.id_live = 1'b1;
		r.status = ampt_pkg::ST_OK;
		return r;
	endfunction

	// apply one request to the shadow table and return its result
	function automatic ampt_pkg::rsp_beat_t table_update(ampt_pkg::req_beat_t q);
		ampt_pkg::rsp_beat_t r;
		int best;
		r = '0;
		best = -1;
		case (q.req_type)
			ampt_pkg::REQ_ADD: begin
				if (next_id >= 64) begin
					r.status = ampt_pkg::ST_FULL;
				end else begin
					pay_mem[next_id] = q.payload;
					pri_mem[next_id] = '0;
					alive[next_id] = 1'b1;
					r = show_entry(next_id[ampt_pkg::ID_W-1:0]);
					next_id++;
				end
			end
			ampt_pkg::REQ_PROMOTE: begin
				if (!entry_live(q.entry_id)) begin
					r.status = ampt_pkg::ST_BAD_ID;
				end else begin
					if (pri_mem[q.entry_id] != '1)
						pri_mem[q.entry_id] = pri_mem[q.entry_id] + 1'b1;
					r = show_entry(q.entry_id);
				end
			end
			ampt_pkg::REQ_GET_MAX, ampt_pkg::REQ_POP_MAX: begin
				for (int i = 0; i < next_id; i++)
					if (alive[i] && (best < 0 || pri_mem[i] >= pri_mem[best]))
						best = i;
				if (best < 0) begin
					r.status = ampt_pkg::ST_EMPTY;
				end else begin
					r = show_entry(best[ampt_pkg::ID_W-1:0]);
					if (q.req_type == ampt_pkg::REQ_POP_MAX)
						alive[best] = 1'b0;
				end
			end
			ampt_pkg::REQ_IS_VAL: begin
				if (entry_live(q.entry_id)) begin
					r = show_entry(q.entry_id);
				end else begin
					r.result_id = q.entry_id;
				end
			end
			ampt_pkg::REQ_GET: begin
				if (!entry_live(q.entry_id))
					r.status = ampt_pkg::ST_BAD_ID;
				else
					r = show_entry(q.entry_id);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ampt_pkg::rsp_beat_t w;
		if (!arst_n) begin
			next_id = 0;
			for (int i = 0; i < 64; i++)
				alive[i] = 1'b0;
			wr_ptr = '0;
			rd_ptr = '0;
			fill = 0;
			mismatches = 0;
		end else begin
			// result compared before the new request is predicted
			if (done) begin
				if (fill == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", rsp);
				end else begin
					w = want_mem[rd_ptr];
					rd_ptr = rd_ptr + 2'd1;
					fill--;
					if (rsp !== w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", w, rsp);
					end
				end
			end
			if (start && !busy) begin
				want_mem[wr_ptr] = table_update(req);
				wr_ptr = wr_ptr + 2'd1;
				fill++;
			end
		end
	end
endmodule

// ===== tb/tb_addressable_max_priority_table.sv =====
`timescale 1ns / 1ps
module tb_addressable_max_priority_table;

	logic                clk;
	logic                arst_n;
	logic                start;
	ampt_pkg::req_beat_t req;
	logic                busy;
	logic                done;
	ampt_pkg::rsp_beat_t rsp;
	int                  fail_count;
	int                  pending;
	int                  idle_pct;

	addressable_max_priority_table i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	ampt_checker i_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hold one beat on the bus until it is taken
	task automatic send_beat(logic [2:0] op, logic [ampt_pkg::ID_W-1:0] id,
			logic [ampt_pkg::DATA_W-1:0] pl);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{req_type: op, entry_id: id, payload: pl};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic random_beat();
		int r;
		logic [2:0] op;
		r = $urandom_range(99);
		if (r < 20) op = ampt_pkg::REQ_ADD;
		else if (r < 55) op = ampt_pkg::REQ_PROMOTE;
		else if (r < 65) op = ampt_pkg::REQ_GET_MAX;
		else if (r < 77) op = ampt_pkg::REQ_POP_MAX;
		else if (r < 86) op = ampt_pkg::REQ_IS_VAL;
		else if (r < 96) op = ampt_pkg::REQ_GET;
		else op = 3'($urandom_range(7));
		send_beat(op, 6'($urandom), $urandom);
	endtask

	initial begin
		int waited;
		start = 1'b0;
		req = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, bad ids, extremes, undefined codes
		send_beat(ampt_pkg::REQ_GET_MAX, '0, '0);
		send_beat(ampt_pkg::REQ_POP_MAX, '0, '0);
		send_beat(ampt_pkg::REQ_GET, 6'd63, '0);
		send_beat(ampt_pkg::REQ_IS_VAL, 6'd63, '0);
		send_beat(ampt_pkg::REQ_PROMOTE, '0, '0);
		send_beat(ampt_pkg::REQ_ADD, '0, '1);
		send_beat(ampt_pkg::REQ_ADD, '1, '0);
		send_beat(ampt_pkg::REQ_ADD, '0, 32'h5a5a_a5a5);
		send_beat(ampt_pkg::REQ_GET_MAX, '0, '0);
		send_beat(ampt_pkg::REQ_PROMOTE, 6'd0, '0);
		send_beat(ampt_pkg::REQ_PROMOTE, 6'd1, '0);
		send_beat(ampt_pkg::REQ_GET_MAX, '0, '0);
		send_beat(ampt_pkg::REQ_IS_VAL, 6'd2, '0);
		send_beat(ampt_pkg::REQ_GET, 6'd1, '0);
		send_beat(ampt_pkg::REQ_POP_MAX, '0, '0);
		send_beat(ampt_pkg::REQ_GET, 6'd1, '0);
		send_beat(ampt_pkg::REQ_PROMOTE, 6'd1, '0);
		send_beat(ampt_pkg::REQ_IS_VAL, 6'd1, '0);
		send_beat(ampt_pkg::REQ_RSVD6, '1, '1);
		send_beat(ampt_pkg::REQ_RSVD7, '1, '1);
		send_beat(ampt_pkg::REQ_GET, 6'd0, '0);

		// random phases with varying sender gaps
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = (ph % 4 == 1) ? 86 : (ph % 4 == 2) ? 26 : 0;
			for (int n = 0; n < 190; n++)
				random_beat();
			// fill to the top so add-when-full is reached
			if (ph == 3)
				for (int n = 0; n < 70; n++)
					send_beat(ampt_pkg::REQ_ADD, 6'($urandom), $urandom);
		end
		start <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_addressable_max_priority_table passed");
		else
			$display("tb_addressable_max_priority_table failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_addressable_max_priority_table failed");
		$finish;
	end
endmodule
